@@ hdl/pmco_pkg.sv @@
// Shared types and constants of the partition matroid circuit oracle.
// Request and result payloads, operation codes, controller states and the
// command and status groups between controller and datapath. No dependencies.
package pmco_pkg;

  localparam int ELEM_W   = 5;
  localparam int PART_W   = 3;
  localparam int CAP_W    = 6;
  localparam int CNT_W    = 6;
  localparam int ECOUNT_W = 6;

  // Largest element index the request field can name, plus one.
  localparam int ELEM_RANGE = 1 << ELEM_W;

  localparam int ECOUNT_RESET     = 32;
  localparam int MAX_ELEMENTS_DEF = 32;
  localparam int PART_COUNT_DEF   = 8;

  typedef enum logic [1:0] {
    OP_ASSIGN_PART  = 2'd0,
    OP_SET_CAPACITY = 2'd1,
    OP_SET_MEMBER   = 2'd2,
    OP_QUERY        = 2'd3
  } op_e;

  typedef struct packed {
    op_e                operation;
    logic [ELEM_W-1:0]  element;
    logic [PART_W-1:0]  part_index;
    logic [CAP_W-1:0]   capacity;
    logic               member;
  } req_t;

  typedef struct packed {
    logic               kind;
    logic [ELEM_W-1:0]  circuit_element;
    logic               last;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_LOOKUP = 2'd1,
    ST_SCAN   = 2'd2,
    ST_FINAL  = 2'd3
  } state_e;

  typedef struct packed {
    logic take;
    logic apply;
    logic scan;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic lookup_needed;
    logic is_query;
    logic query_full;
    logic scan_end;
    logic out_free;
  } dp_status_t;

endpackage

@@ hdl/partition_matroid_circuit_oracle.sv @@
// Partition matroid circuit oracle, top level: controller plus datapath.
// Depends on pmco_pkg, pmco_ctrl, pmco_dpath and pmco_ram.
//
// The block keeps a part number per element, a capacity per part, a
// membership bit per element and a member count per part, and answers
// circuit queries. It works on one request at a time. A capacity write
// needs no table read. A part assignment or a membership change first
// reads the element's current part from the part table, a RAM with a
// registered read port. A query that finds room in its part returns a
// single independent result. A query on a full part scans elements 0 to
// element_count-1 through the same table, one element per cycle while no
// pending result is held back by out_stall_i.
// Results leave through an output register, so the next request can be
// taken while the final result of a query still waits downstream.
// Configuration writes set element_count, which is clamped to the smaller
// of 32 and MAX_ELEMENTS; they are meant for times when no request is in
// flight.
module partition_matroid_circuit_oracle
  import pmco_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int PART_COUNT   = PART_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  req_t                in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rsp_t                out_rsp_o,
  input  logic                cfg_we_i,
  input  logic [ECOUNT_W-1:0] cfg_wdata_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller sequences each request: take, table lookup where needed,
  // then for queries the scan when the part is full, and the final result.
  pmco_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // The datapath holds all tables and counters and the result register.
  pmco_dpath #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .PART_COUNT  (PART_COUNT)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_req_i   (in_req_i),
    .out_stall_i(out_stall_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_rsp_o  (out_rsp_o)
  );

endmodule

@@ hdl/pmco_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the element-to-part table. No package dependencies.
module pmco_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/pmco_ctrl.sv @@
// Controller state machine of the partition matroid circuit oracle.
// Depends on pmco_pkg for the state enum and the command and status structs.
module pmco_ctrl
  import pmco_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (status_i.lookup_needed) begin
            state_d = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        cmd_o.apply = 1'b1;
        if (status_i.is_query) begin
          state_d = status_i.query_full ? ST_SCAN : ST_FINAL;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_end) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        cmd_o.finish = 1'b1;
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/pmco_dpath.sv @@
// Datapath of the partition matroid circuit oracle: tables, counters,
// scan pipeline and output register. Depends on pmco_pkg and pmco_ram.
module pmco_dpath
  import pmco_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int PART_COUNT   = PART_COUNT_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  req_t                in_req_i,
  input  logic                out_stall_i,
  input  logic                cfg_we_i,
  input  logic [ECOUNT_W-1:0] cfg_wdata_i,
  input  dp_cmd_t             cmd_i,
  output dp_status_t          status_o,
  output logic                out_valid_o,
  output rsp_t                out_rsp_o
);

  localparam int AW         = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int PIW        = (PART_COUNT > 1) ? $clog2(PART_COUNT) : 1;
  localparam int SCAN_LIMIT = (MAX_ELEMENTS < ELEM_RANGE) ? MAX_ELEMENTS : ELEM_RANGE;
  localparam int ECOUNT_INIT = (ECOUNT_RESET < SCAN_LIMIT) ? ECOUNT_RESET : SCAN_LIMIT;

  req_t                req_q;
  logic [ECOUNT_W-1:0] ecount_q;
  logic [MAX_ELEMENTS-1:0] member_q, member_d;
  logic [CNT_W-1:0]    count_q [PART_COUNT];
  logic [CNT_W-1:0]    count_d [PART_COUNT];
  logic [CAP_W-1:0]    cap_q   [PART_COUNT];
  logic [PART_COUNT-1:0] inc_sel, dec_sel;
  logic [PART_W-1:0]   part_q;
  logic [ECOUNT_W-1:0] issue_q;
  logic [ELEM_W-1:0]   chk_idx_q;
  logic                chk_valid_q;
  rsp_t                fin_q, out_q, out_load_rsp;
  logic                out_valid_q;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [PART_W-1:0]   ram_rdata;

  logic                in_elem_ok, in_part_ok, req_part_ok;
  logic [AW-1:0]       e_idx;
  logic [PIW-1:0]      old_idx, new_idx;
  logic                full;
  logic                match, hold, more, scan_emit, scan_adv;
  logic                out_can_load, out_load;

  pmco_ram #(
    .WIDTH(PART_W),
    .DEPTH(MAX_ELEMENTS)
  ) u_part_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(req_q.part_index),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Request decode.
  assign in_elem_ok  = int'(in_req_i.element) < MAX_ELEMENTS;
  assign in_part_ok  = int'(in_req_i.part_index) < PART_COUNT;
  assign req_part_ok = int'(req_q.part_index) < PART_COUNT;

  assign e_idx   = AW'(req_q.element);
  assign old_idx = PIW'(ram_rdata);
  assign new_idx = PIW'(req_q.part_index);
  assign full    = !(count_q[old_idx] < cap_q[old_idx]);

  // Count and membership updates, applied once the old part is known.
  always_comb begin
    member_d = member_q;
    inc_sel  = '0;
    dec_sel  = '0;
    if (cmd_i.apply) begin
      case (req_q.operation)
        OP_ASSIGN_PART: begin
          if (req_part_ok && member_q[e_idx]) begin
            dec_sel[old_idx] = 1'b1;
            inc_sel[new_idx] = 1'b1;
          end
        end
        OP_SET_MEMBER: begin
          if (member_q[e_idx] != req_q.member) begin
            member_d[e_idx] = req_q.member;
            if (req_q.member) begin
              inc_sel[old_idx] = 1'b1;
            end else begin
              dec_sel[old_idx] = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    for (int k = 0; k < PART_COUNT; k++) begin
      count_d[k] = count_q[k] + CNT_W'(inc_sel[k]) - CNT_W'(dec_sel[k]);
    end
  end

  // Scan pipeline: one table read in flight, checked the next cycle.
  assign out_can_load = !out_valid_q || !out_stall_i;
  assign match        = member_q[AW'(chk_idx_q)] && (ram_rdata == part_q);
  assign hold         = chk_valid_q && match && !out_can_load;
  assign more         = issue_q < ecount_q;
  assign scan_emit    = cmd_i.scan && chk_valid_q && match && out_can_load;
  assign scan_adv     = cmd_i.scan && !hold;

  assign ram_re    = cmd_i.take || cmd_i.apply || (scan_adv && more);
  assign ram_we    = cmd_i.apply && (req_q.operation == OP_ASSIGN_PART) && req_part_ok;
  assign ram_waddr = e_idx;

  always_comb begin
    if (cmd_i.take) begin
      ram_raddr = AW'(in_req_i.element);
    end else if (cmd_i.apply) begin
      ram_raddr = '0;
    end else begin
      ram_raddr = AW'(issue_q);
    end
  end

  assign out_load = scan_emit || (cmd_i.finish && out_can_load);

  always_comb begin
    if (scan_emit) begin
      out_load_rsp = '{kind: 1'b1, circuit_element: chk_idx_q, last: 1'b0};
    end else begin
      out_load_rsp = fin_q;
    end
  end

  assign status_o.lookup_needed = (in_req_i.operation != OP_SET_CAPACITY) && in_elem_ok;
  assign status_o.is_query      = req_q.operation == OP_QUERY;
  assign status_o.query_full    = full;
  assign status_o.scan_end      = !hold && !more;
  assign status_o.out_free      = out_can_load;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecount_q    <= ECOUNT_W'(ECOUNT_INIT);
      member_q    <= '0;
      for (int k = 0; k < PART_COUNT; k++) begin
        count_q[k] <= '0;
      end
      issue_q     <= '0;
      chk_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ecount_q <= (cfg_wdata_i > ECOUNT_W'(SCAN_LIMIT)) ? ECOUNT_W'(SCAN_LIMIT)
                                                           : cfg_wdata_i;
      end
      member_q <= member_d;
      count_q  <= count_d;
      if (cmd_i.apply) begin
        issue_q     <= ECOUNT_W'(1);
        chk_valid_q <= ecount_q != '0;
      end else if (scan_adv) begin
        if (more) begin
          issue_q     <= issue_q + ECOUNT_W'(1);
          chk_valid_q <= 1'b1;
        end else begin
          chk_valid_q <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      req_q <= in_req_i;
      if ((in_req_i.operation == OP_SET_CAPACITY) && in_part_ok) begin
        cap_q[PIW'(in_req_i.part_index)] <= in_req_i.capacity;
      end
    end
    if (cmd_i.apply) begin
      part_q    <= ram_rdata;
      chk_idx_q <= '0;
      if (full) begin
        fin_q <= '{kind: 1'b1, circuit_element: req_q.element, last: 1'b1};
      end else begin
        fin_q <= '{kind: 1'b0, circuit_element: '0, last: 1'b1};
      end
    end else if (scan_adv && more) begin
      chk_idx_q <= ELEM_W'(issue_q);
    end
    if (out_load) begin
      out_q <= out_load_rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

@@ hdl/pmco_checker.sv @@
// Port-level checks of the partition matroid circuit oracle, and the bind
// that attaches them to the top level. Depends on pmco_pkg.
module pmco_checker
  import pmco_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input req_t                in_req_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input rsp_t                out_rsp_o
);

  logic in_accept;

  assign in_accept = in_valid_i && !in_stall_o;

  // A held result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result changed while stalled");

  // An independent result is always the only, and so the last, one.
  a_indep_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_rsp_o.kind |-> out_rsp_o.last && out_rsp_o.circuit_element == '0)
    else $error("independent result not marked last");

  // A request that needs the part table keeps the block busy next cycle.
  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_req_i.operation != OP_SET_CAPACITY &&
    int'(in_req_i.element) < MAX_ELEMENTS |=> in_stall_o)
    else $error("table request did not occupy the block");

  // A capacity write completes in the cycle it is taken.
  a_cap_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_req_i.operation == OP_SET_CAPACITY |=> !in_stall_o)
    else $error("capacity write occupied the block");

endmodule

bind partition_matroid_circuit_oracle pmco_checker #(
  .MAX_ELEMENTS(MAX_ELEMENTS)
) u_pmco_checker (.*);
